// File: hdl/gbr_pkg.sv
// Shared types, constants and helpers for the 3x3 RGB blur core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package gbr_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int BANKS       = 3;
  localparam int SLOTS       = 4;
  localparam int BANK_DEPTH  = (MAX_WIDTH + BANKS - 1) / BANKS;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int DIM_W       = 11;
  localparam int POS_W       = 2 * DIM_W;
  localparam int WT_W        = 16;
  localparam int PIX_W       = 24;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int CREDIT_W    = FIFO_AW + 1;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_CORNER = 3'd2,
    REG_SIDE   = 3'd3,
    REG_CENTRE = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic               en;
    logic [1:0]         slot;
    logic [1:0]         bank;
    logic [BANK_AW-1:0] addr;
    logic [PIX_W-1:0]   data;
  } line_wr_t;

  typedef struct packed {
    logic       last;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic [1:0] slot;
    logic [1:0] res;
  } job_t;

  typedef struct packed {
    logic [WT_W-1:0] corner;
    logic [WT_W-1:0] side;
    logic [WT_W-1:0] centre;
  } weights_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

  function automatic logic [1:0] res_next(input logic [1:0] r);
    return (r == 2'd2) ? 2'd0 : r + 2'd1;
  endfunction

  // bank holding column offset (j - 1) from a column of residue res
  function automatic logic [1:0] bank_of(input logic [1:0] res, input logic [1:0] j);
    logic [2:0] s;
    logic [1:0] b;
    s = 3'(res) + 3'(j) + 3'd2;
    case (s)
      3'd0, 3'd3, 3'd6: b = 2'd0;
      3'd1, 3'd4, 3'd7: b = 2'd1;
      default:          b = 2'd2;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hdl/gbr_line_store.sv
// Row ring of four rows, each split into three column banks.
// Depends on gbr_pkg; write-first read, one registered read per bank memory.
`timescale 1ns / 1ps
`default_nettype none
module gbr_line_store import gbr_pkg::*; (
  input  wire logic                              clk_i,
  input  wire line_wr_t                          wr_i,
  input  wire logic [BANKS-1:0][BANK_AW-1:0]     raddr_i,
  output logic      [SLOTS-1:0][BANKS-1:0][PIX_W-1:0] rdata_o
);

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
      logic [PIX_W-1:0] mem [BANK_DEPTH];
      logic [PIX_W-1:0] rd_q;
      logic             hit;

      assign hit = wr_i.en && (wr_i.slot == 2'(s)) && (wr_i.bank == 2'(b));

      always_ff @(posedge clk_i) begin
        if (hit) begin
          mem[wr_i.addr] <= wr_i.data;
        end
        if (hit && (wr_i.addr == raddr_i[b])) begin
          rd_q <= wr_i.data;
        end else begin
          rd_q <= mem[raddr_i[b]];
        end
      end

      assign rdata_o[s][b] = rd_q;
    end
  end

endmodule
`default_nettype wire

// File: hdl/gbr_front.sv
// Front end: configuration registers, input and output raster counters,
// result decision and line store addressing. Depends on gbr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbr_front import gbr_pkg::*; (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [WT_W-1:0]               cfg_data_i,
  input  wire logic                          accept_i,
  input  wire logic                          action_i,
  input  wire logic [PIX_W-1:0]              pixel_i,
  output line_wr_t                           wr_o,
  output logic      [BANKS-1:0][BANK_AW-1:0] raddr_o,
  output logic                               emit_o,
  output job_t                               job_o,
  output weights_t                           weights_o,
  output logic                               busy_o
);

  logic [DIM_W-1:0]   w_q, h_q;
  logic [WT_W-1:0]    wk_q, ws_q, wc_q;
  logic [COL_W-1:0]   icol_q, ocol_q;
  logic [BANK_AW-1:0] iq_q, oq_q;
  logic [1:0]         ir_q, or_q, islot_q, oslot_q;
  logic [DIM_W-1:0]   irow_q, orow_q;
  logic [POS_W-1:0]   in_base_q, n_in_q, out_base_q, opos_q;
  logic [POS_W-1:0]   prod_i_q, prod_o_q;
  logic               prev_q, fix1_q, fix2_q;

  logic               pix, wrap_col, wrap_row, prev_set, prev_mid, emit;
  logic               owrap_col, owrap_row;
  logic [DIM_W-1:0]   icol_inc, ocol_inc;
  logic [DIM_W:0]     irow_inc, orow_inc;
  logic [POS_W-1:0]   n_in_d, thr;
  logic [BANK_AW-1:0] q_up, q_dn;

  assign pix      = accept_i && !action_i;
  assign icol_inc = DIM_W'(icol_q) + DIM_W'(1);
  assign wrap_col = icol_inc >= w_q;
  assign irow_inc = {1'b0, irow_q} + (DIM_W+1)'(1);
  assign wrap_row = irow_inc >= {1'b0, h_q};
  assign prev_set = pix && wrap_col && wrap_row;
  assign prev_mid = prev_q || prev_set;

  always_comb begin
    n_in_d = n_in_q;
    if (pix) begin
      if (!wrap_col)      n_in_d = n_in_q + POS_W'(1);
      else if (!wrap_row) n_in_d = in_base_q + POS_W'(w_q);
      else                n_in_d = '0;
    end
  end

  assign thr       = opos_q + POS_W'(w_q) + POS_W'(2);
  assign emit      = accept_i && (prev_mid || (n_in_d >= thr));
  assign ocol_inc  = DIM_W'(ocol_q) + DIM_W'(1);
  assign owrap_col = ocol_inc >= w_q;
  assign orow_inc  = {1'b0, orow_q} + (DIM_W+1)'(1);
  assign owrap_row = orow_inc >= {1'b0, h_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q        <= DIM_W'(512);
      h_q        <= DIM_W'(512);
      wk_q       <= WT_W'(5102);
      ws_q       <= WT_W'(8082);
      wc_q       <= WT_W'(12802);
      icol_q     <= '0;
      iq_q       <= '0;
      ir_q       <= '0;
      irow_q     <= '0;
      islot_q    <= '0;
      in_base_q  <= '0;
      n_in_q     <= '0;
      ocol_q     <= '0;
      oq_q       <= '0;
      or_q       <= '0;
      orow_q     <= '0;
      oslot_q    <= '0;
      out_base_q <= '0;
      opos_q     <= '0;
      prev_q     <= 1'b0;
      fix1_q     <= 1'b0;
      fix2_q     <= 1'b0;
      prod_i_q   <= '0;
      prod_o_q   <= '0;
    end else begin
      fix1_q <= 1'b0;
      fix2_q <= fix1_q;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_WIDTH: begin
            w_q    <= eff_dim(cfg_data_i[DIM_W-1:0], DIM_W'(MAX_WIDTH));
            fix1_q <= 1'b1;
          end
          REG_HEIGHT: h_q  <= eff_dim(cfg_data_i[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
          REG_CORNER: wk_q <= cfg_data_i;
          REG_SIDE:   ws_q <= cfg_data_i;
          REG_CENTRE: wc_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fix1_q) begin
        prod_i_q <= POS_W'(irow_q * w_q);
        prod_o_q <= POS_W'(orow_q * w_q);
      end
      if (fix2_q) begin
        in_base_q  <= prod_i_q;
        n_in_q     <= prod_i_q + POS_W'(icol_q);
        out_base_q <= prod_o_q;
        opos_q     <= prod_o_q + POS_W'(ocol_q);
      end
      if (pix) begin
        n_in_q <= n_in_d;
        if (!wrap_col) begin
          icol_q <= icol_q + COL_W'(1);
          ir_q   <= res_next(ir_q);
          if (ir_q == 2'd2) iq_q <= iq_q + BANK_AW'(1);
        end else begin
          icol_q  <= '0;
          iq_q    <= '0;
          ir_q    <= '0;
          islot_q <= islot_q + 2'd1;
          if (!wrap_row) begin
            irow_q    <= irow_q + DIM_W'(1);
            in_base_q <= in_base_q + POS_W'(w_q);
          end else begin
            irow_q    <= '0;
            in_base_q <= '0;
          end
        end
      end
      if (accept_i) prev_q <= prev_mid;
      if (emit) begin
        if (!owrap_col) begin
          ocol_q <= ocol_q + COL_W'(1);
          or_q   <= res_next(or_q);
          if (or_q == 2'd2) oq_q <= oq_q + BANK_AW'(1);
          opos_q <= opos_q + POS_W'(1);
        end else begin
          ocol_q  <= '0;
          oq_q    <= '0;
          or_q    <= '0;
          oslot_q <= oslot_q + 2'd1;
          if (!owrap_row) begin
            orow_q     <= orow_q + DIM_W'(1);
            out_base_q <= out_base_q + POS_W'(w_q);
            opos_q     <= out_base_q + POS_W'(w_q);
          end else begin
            orow_q     <= '0;
            out_base_q <= '0;
            opos_q     <= '0;
            prev_q     <= 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    wr_o.en   = pix;
    wr_o.slot = islot_q;
    wr_o.bank = ir_q;
    wr_o.addr = iq_q;
    wr_o.data = pixel_i;
  end

  assign q_up = (or_q == 2'd2) ? oq_q + BANK_AW'(1) : oq_q;
  assign q_dn = (or_q == 2'd0) ? oq_q - BANK_AW'(1) : oq_q;

  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      if (2'(b) == or_q)                raddr_o[b] = oq_q;
      else if (2'(b) == res_next(or_q)) raddr_o[b] = q_up;
      else                              raddr_o[b] = q_dn;
    end
  end

  always_comb begin
    job_o.last      = owrap_row && owrap_col;
    job_o.row_ok[0] = (orow_q != '0) && (orow_q <= h_q);
    job_o.row_ok[1] = orow_q < h_q;
    job_o.row_ok[2] = orow_inc < {1'b0, h_q};
    job_o.col_ok[0] = (ocol_q != '0) && (DIM_W'(ocol_q) <= w_q);
    job_o.col_ok[1] = DIM_W'(ocol_q) < w_q;
    job_o.col_ok[2] = ocol_inc < w_q;
    job_o.slot      = oslot_q;
    job_o.res       = or_q;
  end

  assign emit_o    = emit;
  assign weights_o = '{corner: wk_q, side: ws_q, centre: wc_q};
  assign busy_o    = fix1_q || fix2_q;

endmodule
`default_nettype wire

// File: hdl/gbr_back.sv
// Back end: window selection, weighted sums per channel, saturation and
// the result queue. Depends on gbr_pkg; fed by gbr_front and gbr_line_store.
`timescale 1ns / 1ps
`default_nettype none
module gbr_back import gbr_pkg::*; (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    emit_i,
  input  wire job_t                                    job_i,
  input  wire weights_t                                weights_i,
  input  wire logic [SLOTS-1:0][BANKS-1:0][PIX_W-1:0]  rdata_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic      [PIX_W-1:0]                        out_pixel_o,
  output logic                                         out_last_o
);

  localparam int SUM_W = 10;
  localparam int PRD_W = SUM_W + WT_W;
  localparam int ACC_W = PRD_W + 2;

  logic             j_vld_q, a_vld_q, a_last_q;
  job_t             job_q;
  logic [2:0][PRD_W-1:0] pk_q, ps_q, pc_q;

  logic [2:0][2:0][PIX_W-1:0] win;
  logic [2:0][SUM_W-1:0]      sk, ss;
  logic [2:0][7:0]            sc;
  logic [PIX_W-1:0]           res_pix;

  logic [PIX_W:0]   fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [CREDIT_W-1:0] cnt_q;
  logic             pop;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (job_q.row_ok[k] && job_q.col_ok[j]) begin
          win[k][j] = rdata_i[job_q.slot + 2'(k) - 2'd1][bank_of(job_q.res, 2'(j))];
        end else begin
          win[k][j] = '0;
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      sk[c] = SUM_W'(win[0][0][8*c +: 8]) + SUM_W'(win[0][2][8*c +: 8])
            + SUM_W'(win[2][0][8*c +: 8]) + SUM_W'(win[2][2][8*c +: 8]);
      ss[c] = SUM_W'(win[0][1][8*c +: 8]) + SUM_W'(win[1][0][8*c +: 8])
            + SUM_W'(win[1][2][8*c +: 8]) + SUM_W'(win[2][1][8*c +: 8]);
      sc[c] = win[1][1][8*c +: 8];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [ACC_W-1:0] acc;
      acc = ACC_W'(pk_q[c]) + ACC_W'(ps_q[c]) + ACC_W'(pc_q[c]);
      res_pix[8*c +: 8] = (acc[ACC_W-1:16] > (ACC_W-16)'(255)) ? 8'hFF : acc[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) job_q <= job_i;
    if (j_vld_q) begin
      a_last_q <= job_q.last;
      for (int c = 0; c < 3; c++) begin
        pk_q[c] <= sk[c] * weights_i.corner;
        ps_q[c] <= ss[c] * weights_i.side;
        pc_q[c] <= PRD_W'(sc[c] * weights_i.centre);
      end
    end
    if (a_vld_q) fifo_q[wp_q] <= {a_last_q, res_pix};
  end

  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_vld_q <= 1'b0;
      a_vld_q <= 1'b0;
      wp_q    <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
    end else begin
      j_vld_q <= emit_i;
      a_vld_q <= j_vld_q;
      if (a_vld_q) wp_q <= wp_q + FIFO_AW'(1);
      if (pop)     rp_q <= rp_q + FIFO_AW'(1);
      cnt_q <= cnt_q + CREDIT_W'(a_vld_q) - CREDIT_W'(pop);
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign out_pixel_o = fifo_q[rp_q][PIX_W-1:0];
  assign out_last_o  = fifo_q[rp_q][PIX_W];

endmodule
`default_nettype wire

// File: hdl/gaussian_blur_3x3_rgb_core.sv
// Top level of the 3x3 RGB blur core: flow control and wiring of front end,
// line store and back end. Depends on gbr_pkg, gbr_front, gbr_line_store, gbr_back.
//
// Input channel: one item a cycle while in_ready_o is high, a pixel (action 0)
// or a flush step (action 1). Each item gives zero or one result; in a steady
// raster stream result (r,c) is caused by input (r+1,c+1), and flush steps after
// the last pixel drain the final row. Results leave in order on the output channel
// with last_of_frame set on the last pixel of each frame.
// Throughput: one item per cycle while in_ready_o is high, set by the counter
// update in the front end and one read per line store bank per cycle.
// A result-causing item passes the line store read, the weighting stage and
// the result queue before out_valid_o rises.
// A four-entry result queue with credit counting keeps input flowing while
// the receiver stalls; with the queue and pipeline full, in_ready_o drops
// until a result is taken.
// Configuration: write register index and data; taken at once. A write of
// the image width recomputes raster positions, holding in_ready_o low until the
// recompute is done. Reset restores the default size and weights and empties the
// pipeline; line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_blur_3x3_rgb_core import gbr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic             last_of_frame_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic                              accept, emit, busy, pop;
  logic [CREDIT_W-1:0]               credit_q;
  line_wr_t                          wr;
  logic [BANKS-1:0][BANK_AW-1:0]     raddr;
  logic [SLOTS-1:0][BANKS-1:0][PIX_W-1:0] rdata;
  job_t                              job;
  weights_t                          weights;
  logic [PIX_W-1:0]                  out_pixel;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (credit_q < CREDIT_W'(FIFO_DEPTH)) && !busy;
  assign accept      = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_q + CREDIT_W'(emit) - CREDIT_W'(pop);
    end
  end

  gbr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .action_i    (action_i),
    .pixel_i     ({red_in_i, green_in_i, blue_in_i}),
    .wr_o        (wr),
    .raddr_o     (raddr),
    .emit_o      (emit),
    .job_o       (job),
    .weights_o   (weights),
    .busy_o      (busy)
  );

  gbr_line_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  gbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .job_i       (job),
    .weights_i   (weights),
    .rdata_i     (rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pixel_o (out_pixel),
    .out_last_o  (last_of_frame_o)
  );

  assign red_out_o   = out_pixel[23:16];
  assign green_out_o = out_pixel[15:8];
  assign blue_out_o  = out_pixel[7:0];

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CREDIT_W'(FIFO_DEPTH))
    else $error("result credits exceed queue depth");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (credit_q == '0) |-> !out_valid_o)
    else $error("result shown with nothing in flight");

  a_hold_on_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !accept)
    else $error("item taken during position recompute");

  a_emit_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> accept)
    else $error("result issued without an item");

endmodule
`default_nettype wire

// File: tb/gaussian_blur_3x3_rgb_core_test.sv
// Self-checking testbench for gaussian_blur_3x3_rgb_core: raster frames of RGB
// pixels and flush steps, checked against an in-bench 3x3 blur predictor.
// Depends on gbr_pkg and the block's RTL.
`timescale 1ns / 1ps
module gaussian_blur_3x3_rgb_core_test import gbr_pkg::*;;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;
  localparam int   ITEM_TARGET = 1700;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } blurred_px_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        action_i;
  logic [7:0]  red_in_i;
  logic [7:0]  green_in_i;
  logic [7:0]  blue_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic        last_of_frame_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  gaussian_blur_3x3_rgb_core dut (.*);

  // predictor state
  logic [23:0] row_ring [4][MAX_WIDTH];
  int unsigned width_reg, height_reg, corner_wt, side_wt, centre_wt;
  int unsigned in_col, in_row, out_col, out_row, in_slot, out_slot;
  bit          draining_prev;

  blurred_px_t expected_px[$];
  int          mismatches;
  int          items_sent;
  bit          tx_quiet, rx_quiet;
  int          rx_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_chan();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic int unsigned frame_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned frame_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void apply_reg(cfg_reg_e idx, logic [15:0] v);
    case (idx)
      REG_WIDTH:  width_reg  = 32'(v & 16'h07FF);
      REG_HEIGHT: height_reg = 32'(v & 16'h07FF);
      REG_CORNER: corner_wt  = 32'(v);
      REG_SIDE:   side_wt    = 32'(v);
      REG_CENTRE: centre_wt  = 32'(v);
      default: ;
    endcase
  endfunction

  function automatic void blur_step(logic act, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b);
    int unsigned w, h, wt, slot, sum_r, sum_g, sum_b;
    longint      rr, cc, n_in, o_pos;
    logic [23:0] px;
    blurred_px_t res;
    w = frame_width();
    h = frame_height();
    if (act == ACT_PIXEL) begin
      row_ring[in_slot][in_col % MAX_WIDTH] = {r, g, b};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        in_slot = (in_slot + 1) & 3;
        if (in_row >= h) begin
          in_row = 0;
          draining_prev = 1'b1;
        end
      end
    end
    n_in  = longint'(in_row) * w + in_col;
    o_pos = longint'(out_row) * w + out_col;
    if (!draining_prev && n_in < o_pos + w + 2) return;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = longint'(out_row) + dr;
        cc = longint'(out_col) + dc;
        if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
        if (dr == 0 && dc == 0) wt = centre_wt;
        else if (dr == 0 || dc == 0) wt = side_wt;
        else wt = corner_wt;
        slot = (out_slot + 4 + dr) & 3;
        px = row_ring[slot][cc % MAX_WIDTH];
        sum_r += px[23:16] * wt;
        sum_g += px[15:8] * wt;
        sum_b += px[7:0] * wt;
      end
    end
    sum_r >>= 16;
    sum_g >>= 16;
    sum_b >>= 16;
    res.red   = sum_r > 255 ? 8'hFF : sum_r[7:0];
    res.green = sum_g > 255 ? 8'hFF : sum_g[7:0];
    res.blue  = sum_b > 255 ? 8'hFF : sum_b[7:0];
    res.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
    expected_px.push_back(res);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      out_slot = (out_slot + 1) & 3;
      if (out_row >= h) begin
        out_row = 0;
        draining_prev = 1'b0;
      end
    end
  endfunction

  task automatic send_item(logic act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    blur_step(act, r, g, b);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(logic [15:0] w, logic [15:0] h, logic [15:0] wc,
                           logic [15:0] ws, logic [15:0] wm);
    wait_drained();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_CORNER, wc);
    cfg_write(REG_SIDE, ws);
    cfg_write(REG_CENTRE, wm);
  endtask

  task automatic run_frame(bit drain, bit noisy);
    int unsigned n;
    n = frame_width() * frame_height();
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(19) == 0)
        send_item(ACT_FLUSH, pick_chan(), pick_chan(), pick_chan());
      send_item(ACT_PIXEL, pick_chan(), pick_chan(), pick_chan());
    end
    if (drain) begin
      while (draining_prev) send_item(ACT_FLUSH, pick_chan(), pick_chan(), pick_chan());
      if ($urandom_range(3) == 0)
        send_item(ACT_FLUSH, pick_chan(), pick_chan(), pick_chan());
    end
  endtask

  task automatic test_flush_on_idle();
    send_item(ACT_FLUSH, 8'hFF, 8'h00, 8'hFF);
    send_item(ACT_FLUSH, 8'h00, 8'hFF, 8'h00);
  endtask

  task automatic test_default_weights();
    wait_drained();
    cfg_write(REG_WIDTH, 16'h0003);
    cfg_write(REG_HEIGHT, 16'h0003);
    // early flush: frame incomplete, nothing given
    send_item(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(ACT_FLUSH, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < 8; i++) send_item(ACT_PIXEL, 8'hFF, 8'h80, 8'h00);
    while (draining_prev) send_item(ACT_FLUSH, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_weight_extremes();
    set_frame(16'h0004, 16'h0002, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_frame(1'b1, 1'b0);
    set_frame(16'hF803, 16'h0003, 16'h0000, 16'h0000, 16'h0000);
    run_frame(1'b1, 1'b0);
    set_frame(16'h0002, 16'h0002, 16'h5555, 16'hAAAA, 16'h0001);
    run_frame(1'b1, 1'b0);
  endtask

  task automatic test_degenerate_sizes();
    set_frame(16'h0000, 16'h0000, 16'd5102, 16'd8082, 16'd12802);
    run_frame(1'b1, 1'b0);
    set_frame(16'h0005, 16'h0001, 16'd9000, 16'd9000, 16'd20000);
    run_frame(1'b1, 1'b0);
    set_frame(16'h0001, 16'h07FF, 16'd5102, 16'd8082, 16'd12802);
    run_frame(1'b1, 1'b0);
  endtask

  task automatic test_back_to_back_frames();
    set_frame(16'h0004, 16'h0003, 16'd5102, 16'd8082, 16'd12802);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_frame(1'b0, 1'b0);
    run_frame(1'b0, 1'b0);
    run_frame(1'b1, 1'b0);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_output_stall();
    set_frame(16'd16, 16'h0004, 16'd4000, 16'd7000, 16'd15000);
    tx_quiet = 1'b1;
    rx_hold  = 400;
    run_frame(1'b1, 1'b0);
    tx_quiet = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned w, h;
    int          mode;
    while (items_sent < ITEM_TARGET) begin
      if (!draining_prev && $urandom_range(2) != 0) begin
        w = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 64);
        h = $urandom_range(1, 6);
        mode = $urandom_range(2);
        if (mode == 0)
          set_frame(16'(w), 16'(h), 16'd5102, 16'd8082, 16'd12802);
        else if (mode == 1)
          set_frame(16'(w), 16'(h), 16'($urandom_range(0, 12000)),
                    16'($urandom_range(0, 12000)), 16'($urandom_range(0, 20000)));
        else
          set_frame(16'(w), 16'(h), 16'($urandom), 16'($urandom), 16'($urandom));
      end
      tx_quiet = ($urandom_range(7) == 0);
      rx_quiet = ($urandom_range(7) == 0);
      run_frame($urandom_range(3) != 0, 1'b1);
    end
    tx_quiet = 1'b0;
    while (draining_prev) send_item(ACT_FLUSH, pick_chan(), pick_chan(), pick_chan());
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = rx_quiet ? 0 : pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    blurred_px_t exp_px;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: rgb %h %h %h last %b", red_out_o, green_out_o,
                   blue_out_o, last_of_frame_o);
      end else begin
        exp_px = expected_px.pop_front();
        if (exp_px.red !== red_out_o || exp_px.green !== green_out_o ||
            exp_px.blue !== blue_out_o || exp_px.last !== last_of_frame_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rgb %h %h %h last %b, got %h %h %h last %b",
                     exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                     red_out_o, green_out_o, blue_out_o, last_of_frame_o);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = ACT_PIXEL;
    red_in_i    = 8'h00;
    green_in_i  = 8'h00;
    blue_in_i   = 8'h00;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_WIDTH;
    cfg_data_i  = 16'h0000;
    tx_quiet    = 1'b0;
    rx_quiet    = 1'b0;
    rx_hold     = 0;
    mismatches  = 0;
    items_sent  = 0;
    width_reg   = 512;
    height_reg  = 512;
    corner_wt   = 5102;
    side_wt     = 8082;
    centre_wt   = 12802;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    in_slot = 0; out_slot = 0;
    draining_prev = 1'b0;
    for (int s = 0; s < 4; s++)
      for (int c = 0; c < MAX_WIDTH; c++) row_ring[s][c] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    test_flush_on_idle();
    test_default_weights();
    test_weight_extremes();
    test_degenerate_sizes();
    test_back_to_back_frames();
    test_output_stall();
    test_random_frames();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_px.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
